// File: design/cart_pkg.sv
package cart_pkg;

	localparam int SLOTS = 8;
	localparam int NODE_LIMIT = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam logic [1:0] MODE_SEND = 2'd0;
	localparam logic [1:0] MODE_ACK = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	localparam logic [1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
	localparam logic [1:0] CFG_HEARTBEAT = 2'd2;

	typedef enum logic [2:0] {
		EV_ADDED = 3'd0,
		EV_FULL = 3'd1,
		EV_UNTRACKED = 3'd2,
		EV_ACK_MATCH = 3'd3,
		EV_ACK_MISS = 3'd4,
		EV_RESEND = 3'd5,
		EV_GAVE_UP = 3'd6,
		EV_SCAN_DONE = 3'd7
	} ev_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] target_id;
		logic [7:0] command_code;
		logic [31:0] echoed_stamp;
		logic [31:0] now_ms;
	} cmd_t;

	typedef struct packed {
		ev_t event_res;
		logic [2:0] slot;
		logic [7:0] out_target;
		logic [7:0] out_code;
		logic [31:0] out_stamp;
		logic [3:0] attempt;
		logic [3:0] pending_count;
		logic last;
	} res_t;

	typedef struct packed {
		logic [15:0] timeout;
		logic [3:0] retry_limit;
		logic [7:0] heartbeat;
	} cfg_t;

	typedef struct packed {
		logic pend;
		logic [7:0] target;
		logic [7:0] code;
		logic [31:0] stamp;
		logic [31:0] sent;
		logic [3:0] retries;
	} entry_t;

	typedef enum logic [1:0] {
		TOP_NONE = 2'd0,
		TOP_NEW = 2'd1,
		TOP_RETRY = 2'd2,
		TOP_CLEAR = 2'd3
	} tbl_op_t;

	typedef struct packed {
		tbl_op_t op;
		logic [SLOT_W-1:0] idx;
		logic [7:0] target;
		logic [7:0] code;
		logic [31:0] now;
	} tbl_wr_t;

endpackage

// File: design/command_ack_retry_tracker_top.sv
// channel  direction  handshake                word
// in       input      in_valid / in_ready      in_data (cmd_t)
// out      output     out_valid / out_ready    out_data (res_t)
// cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// one slot of the table is examined per cycle by a single subtract/compare unit,
// except while a hit waits for the output register to be free
// a result waits in the output register while the scan moves on until the next hit
// arst_n clears pending flags, count, state and config to their defaults
// cfg writes are taken every cycle
module command_ack_retry_tracker_top
	import cart_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cmd_t in_data,
	output logic out_valid,
	input logic out_ready,
	output res_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	cfg_t cfg_q;
	entry_t rd;
	tbl_wr_t wr;
	logic [SLOT_W-1:0] rd_idx;
	logic [CNT_W-1:0] total;
	logic res_valid;
	res_t res;
	logic res_free;
	logic out_valid_q;
	res_t out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout <= 16'd1000;
			cfg_q.retry_limit <= 4'd3;
			cfg_q.heartbeat <= 8'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TIMEOUT: cfg_q.timeout <= cfg_data;
				CFG_RETRY_LIMIT: cfg_q.retry_limit <= cfg_data[3:0];
				CFG_HEARTBEAT: cfg_q.heartbeat <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	cart_table u_table (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.rd_idx(rd_idx),
		.rd(rd),
		.total(total)
	);

	cart_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.cfg(cfg_q),
		.rd(rd),
		.total(total),
		.rd_idx(rd_idx),
		.wr(wr),
		.res_valid(res_valid),
		.res(res),
		.res_free(res_free)
	);

	// output register
	assign res_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_free) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.pending_count <= 4'(SLOTS))
		else $error("pending count above table size");

	a_not_last_is_scan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |->
		(out_data.event_res == EV_RESEND || out_data.event_res == EV_GAVE_UP))
		else $error("non-final word is not a tick event");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.mode == MODE_TICK |=> !in_ready)
		else $error("tick accepted without a scan");

	a_table_count: assert property (@(posedge clk) disable iff (!arst_n)
		wr.op == TOP_NEW |-> total < CNT_W'(SLOTS))
		else $error("slot added to a full table");
`endif

endmodule

// File: design/cart_table.sv
module cart_table
	import cart_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input tbl_wr_t wr,
	input logic [SLOT_W-1:0] rd_idx,
	output entry_t rd,
	output logic [CNT_W-1:0] total
);

	logic [SLOTS-1:0] pend_q;
	logic [CNT_W-1:0] total_q;
	logic [7:0] target_q [SLOTS];
	logic [7:0] code_q [SLOTS];
	logic [31:0] stamp_q [SLOTS];
	logic [31:0] sent_q [SLOTS];
	logic [3:0] retries_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			total_q <= '0;
		end else begin
			case (wr.op)
				TOP_NEW: begin
					pend_q[wr.idx] <= 1'b1;
					total_q <= total_q + CNT_W'(1);
				end
				TOP_CLEAR: begin
					pend_q[wr.idx] <= 1'b0;
					total_q <= total_q - CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (wr.op)
			TOP_NEW: begin
				target_q[wr.idx] <= wr.target;
				code_q[wr.idx] <= wr.code;
				stamp_q[wr.idx] <= wr.now;
				sent_q[wr.idx] <= wr.now;
				retries_q[wr.idx] <= 4'd0;
			end
			TOP_RETRY: begin
				retries_q[wr.idx] <= retries_q[wr.idx] + 4'd1;
				sent_q[wr.idx] <= wr.now;
			end
			default: ;
		endcase
	end

	always_comb begin
		rd.pend = pend_q[rd_idx];
		rd.target = target_q[rd_idx];
		rd.code = code_q[rd_idx];
		rd.stamp = stamp_q[rd_idx];
		rd.sent = sent_q[rd_idx];
		rd.retries = retries_q[rd_idx];
	end

	assign total = total_q;

endmodule

// File: design/cart_seq.sv
module cart_seq
	import cart_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cmd_t in_data,
	input cfg_t cfg,
	input entry_t rd,
	input logic [CNT_W-1:0] total,
	output logic [SLOT_W-1:0] rd_idx,
	output tbl_wr_t wr,
	output logic res_valid,
	output res_t res,
	input logic res_free
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN = 3'b100
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic [SLOT_W-1:0] idx_q;
	ev_t fin_ev_q;

	logic [31:0] elapsed;
	logic expired;
	logic match;
	logic hit;
	logic give_up;
	logic last_idx;
	logic fire;
	logic untracked;
	ev_t miss_ev;

	// shared per-slot compare unit
	assign elapsed = cmd_q.now_ms - rd.sent;
	assign expired = elapsed >= {16'd0, cfg.timeout};
	assign match = (rd.target == cmd_q.target_id) && (rd.code == cmd_q.command_code)
		&& (rd.stamp == cmd_q.echoed_stamp);
	assign give_up = rd.retries >= cfg.retry_limit;
	assign last_idx = idx_q == SLOT_W'(SLOTS - 1);
	assign untracked = ({1'b0, in_data.target_id} >= 9'(NODE_LIMIT))
		|| (in_data.command_code == cfg.heartbeat);
	assign rd_idx = idx_q;
	assign in_ready = state_q == ST_IDLE;
	assign fire = res_valid && res_free;

	always_comb begin
		case (cmd_q.mode)
			MODE_SEND: hit = !rd.pend;
			MODE_ACK: hit = rd.pend && match;
			MODE_TICK: hit = rd.pend && expired;
			default: hit = 1'b0;
		endcase
		case (cmd_q.mode)
			MODE_SEND: miss_ev = EV_FULL;
			MODE_ACK: miss_ev = EV_ACK_MISS;
			default: miss_ev = EV_SCAN_DONE;
		endcase
	end

	always_comb begin
		res_valid = 1'b0;
		res = '0;
		res.event_res = EV_SCAN_DONE;
		res.pending_count = 4'(total);
		res.last = 1'b1;
		wr.op = TOP_NONE;
		wr.idx = idx_q;
		wr.target = cmd_q.target_id;
		wr.code = cmd_q.command_code;
		wr.now = cmd_q.now_ms;
		unique case (state_q)
			ST_SCAN: begin
				res_valid = hit;
				res.slot = 3'(idx_q);
				case (cmd_q.mode)
					MODE_SEND: begin
						res.event_res = EV_ADDED;
						res.out_target = cmd_q.target_id;
						res.out_code = cmd_q.command_code;
						res.out_stamp = cmd_q.now_ms;
						res.pending_count = 4'(total + CNT_W'(1));
						if (fire) begin
							wr.op = TOP_NEW;
						end
					end
					MODE_ACK: begin
						res.event_res = EV_ACK_MATCH;
						res.out_target = cmd_q.target_id;
						res.out_code = cmd_q.command_code;
						res.out_stamp = cmd_q.echoed_stamp;
						res.attempt = rd.retries;
						res.pending_count = 4'(total - CNT_W'(1));
						if (fire) begin
							wr.op = TOP_CLEAR;
						end
					end
					default: begin
						res.out_target = rd.target;
						res.out_code = rd.code;
						res.out_stamp = rd.stamp;
						res.last = 1'b0;
						if (give_up) begin
							res.event_res = EV_GAVE_UP;
							res.attempt = rd.retries;
							res.pending_count = 4'(total - CNT_W'(1));
							if (fire) begin
								wr.op = TOP_CLEAR;
							end
						end else begin
							res.event_res = EV_RESEND;
							res.attempt = rd.retries + 4'd1;
							if (fire) begin
								wr.op = TOP_RETRY;
							end
						end
					end
				endcase
			end
			ST_FIN: begin
				res_valid = 1'b1;
				res.event_res = fin_ev_q;
				if (fin_ev_q != EV_SCAN_DONE) begin
					res.out_target = cmd_q.target_id;
					res.out_code = cmd_q.command_code;
					res.out_stamp = (fin_ev_q == EV_ACK_MISS) ? cmd_q.echoed_stamp
						: cmd_q.now_ms;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			fin_ev_q <= EV_SCAN_DONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_valid) begin
						if (in_data.mode == MODE_SEND && untracked) begin
							fin_ev_q <= EV_UNTRACKED;
							state_q <= ST_FIN;
						end else if (in_data.mode == MODE_SEND || in_data.mode == MODE_ACK
							|| in_data.mode == MODE_TICK) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						if (fire) begin
							if (cmd_q.mode != MODE_TICK) begin
								state_q <= ST_IDLE;
							end else if (last_idx) begin
								fin_ev_q <= EV_SCAN_DONE;
								state_q <= ST_FIN;
							end else begin
								idx_q <= idx_q + SLOT_W'(1);
							end
						end
					end else if (last_idx) begin
						fin_ev_q <= miss_ev;
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end
				ST_FIN: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q <= in_data;
		end
	end

endmodule

// File: verif/command_ack_retry_tracker_top_tb.sv
module command_ack_retry_tracker_top_tb;
	import cart_pkg::*;

	localparam logic [1:0] MODE_IDLE = 2'd3;
	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam logic [31:0] WRAP_BASE = 32'hFFFF_FF00;
	localparam res_t NO_EV = '0;

	typedef struct packed {
		cmd_t c;
		logic chk;
		res_t r;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	cmd_t in_data;
	logic out_valid;
	logic out_ready;
	res_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	// shadow of the tracker table and registers
	logic sl_pend [SLOTS];
	logic [7:0] sl_tgt [SLOTS];
	logic [7:0] sl_code [SLOTS];
	logic [31:0] sl_stamp [SLOTS];
	logic [31:0] sl_sent [SLOTS];
	logic [3:0] sl_retry [SLOTS];
	logic [3:0] pend_cnt;
	logic [15:0] timeout_ms;
	logic [3:0] retry_max;
	logic [7:0] hb_code;

	res_t awaited_events [$];
	res_t want;
	logic [31:0] run_ms;
	int fault_count = 0;
	int words_seen = 0;
	int tx_burst = 0;
	int rx_burst = 0;
	int rx_gap;
	bit long_hold_done = 1'b0;
	int k;
	int p;
	int n;
	cmd_t item;
	logic [15:0] set_timeout;
	logic [3:0] set_retry;
	logic [7:0] set_hb;
	logic [11:0] pad;

	dir_row_t dir_rows [24] = '{
		'{'{MODE_TICK, 8'd0, 8'd0, 32'd0, 32'd0}, 1'b1,
			'{EV_SCAN_DONE, 3'd0, 8'd0, 8'd0, 32'd0, 4'd0, 4'd0, 1'b1}},
		'{'{MODE_SEND, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
			'{EV_UNTRACKED, 3'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 4'd0, 4'd0, 1'b1}},
		'{'{MODE_SEND, 8'd255, 8'd255, 32'd0, 32'd0}, 1'b1,
			'{EV_UNTRACKED, 3'd0, 8'd255, 8'd255, 32'd0, 4'd0, 4'd0, 1'b1}},
		'{'{MODE_SEND, 8'd16, 8'h5A, 32'd0, 32'h1234_5678}, 1'b1,
			'{EV_UNTRACKED, 3'd0, 8'd16, 8'h5A, 32'h1234_5678, 4'd0, 4'd0, 1'b1}},
		'{'{MODE_SEND, 8'd15, 8'd255, 32'hFFFF_FFFF, WRAP_BASE}, 1'b1,
			'{EV_ADDED, 3'd0, 8'd15, 8'd255, WRAP_BASE, 4'd0, 4'd1, 1'b1}},
		'{'{MODE_SEND, 8'd0, 8'd1, 32'd0, 32'd100}, 1'b1,
			'{EV_ADDED, 3'd1, 8'd0, 8'd1, 32'd100, 4'd0, 4'd2, 1'b1}},
		'{'{MODE_ACK, 8'd15, 8'd255, WRAP_BASE + 32'd1, 32'd0}, 1'b1,
			'{EV_ACK_MISS, 3'd0, 8'd15, 8'd255, WRAP_BASE + 32'd1, 4'd0, 4'd2, 1'b1}},
		'{'{MODE_ACK, 8'd0, 8'd1, 32'd100, 32'd0}, 1'b1,
			'{EV_ACK_MATCH, 3'd1, 8'd0, 8'd1, 32'd100, 4'd0, 4'd1, 1'b1}},
		'{'{MODE_IDLE, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, NO_EV},
		'{'{MODE_TICK, 8'd0, 8'd0, 32'd0, WRAP_BASE + 32'd999}, 1'b0, NO_EV},
		'{'{MODE_TICK, 8'd0, 8'd0, 32'd0, WRAP_BASE + 32'd1000}, 1'b0, NO_EV},
		'{'{MODE_TICK, 8'd0, 8'd0, 32'd0, WRAP_BASE + 32'd2000}, 1'b0, NO_EV},
		'{'{MODE_TICK, 8'd0, 8'd0, 32'd0, WRAP_BASE + 32'd3000}, 1'b0, NO_EV},
		'{'{MODE_TICK, 8'd0, 8'd0, 32'd0, WRAP_BASE + 32'd4000}, 1'b0, NO_EV},
		'{'{MODE_SEND, 8'd1, 8'h11, 32'd0, 32'h0000_0100}, 1'b0, NO_EV},
		'{'{MODE_SEND, 8'd2, 8'h12, 32'd0, 32'h0000_0200}, 1'b0, NO_EV},
		'{'{MODE_SEND, 8'd3, 8'h13, 32'd0, 32'h0000_0300}, 1'b0, NO_EV},
		'{'{MODE_SEND, 8'd4, 8'h14, 32'd0, 32'h0000_0400}, 1'b0, NO_EV},
		'{'{MODE_SEND, 8'd5, 8'h15, 32'd0, 32'h0000_0500}, 1'b0, NO_EV},
		'{'{MODE_SEND, 8'd6, 8'h16, 32'd0, 32'h0000_0600}, 1'b0, NO_EV},
		'{'{MODE_SEND, 8'd7, 8'h17, 32'd0, 32'h0000_0700}, 1'b0, NO_EV},
		'{'{MODE_SEND, 8'd8, 8'h18, 32'd0, 32'h0000_0800}, 1'b0, NO_EV},
		'{'{MODE_SEND, 8'd9, 8'h33, 32'd0, 32'h8000_0000}, 1'b1,
			'{EV_FULL, 3'd0, 8'd9, 8'h33, 32'h8000_0000, 4'd0, 4'd8, 1'b1}},
		'{'{MODE_ACK, 8'd3, 8'h13, 32'h0000_0300, 32'd0}, 1'b0, NO_EV}
	};

	command_ack_retry_tracker_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic res_t mk_event(ev_t ev, int sl, logic [7:0] tg, logic [7:0] cd,
			logic [31:0] st, logic [3:0] at, logic lst);
		res_t r;
		r.event_res = ev;
		r.slot = sl[2:0];
		r.out_target = tg;
		r.out_code = cd;
		r.out_stamp = st;
		r.attempt = at;
		r.pending_count = pend_cnt;
		r.last = lst;
		return r;
	endfunction

	function automatic string fmt_res(res_t r);
		return $sformatf("ev=%0d slot=%0d tgt=%02h code=%02h stamp=%08h att=%0d pend=%0d last=%0b",
			r.event_res, r.slot, r.out_target, r.out_code, r.out_stamp, r.attempt,
			r.pending_count, r.last);
	endfunction

	function automatic int draw_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			burst = $urandom_range(8, 30);
		return $urandom_range(0, 6);
	endfunction

	task automatic clear_table();
		int i;
		timeout_ms = 16'd1000;
		retry_max = 4'd3;
		hb_code = 8'd0;
		pend_cnt = '0;
		for (i = 0; i < SLOTS; i++) begin
			sl_pend[i] = 1'b0;
			sl_tgt[i] = '0;
			sl_code[i] = '0;
			sl_stamp[i] = '0;
			sl_sent[i] = '0;
			sl_retry[i] = '0;
		end
	endtask

	// expected events for one accepted command word
	task automatic track_cmd(input cmd_t c);
		int i;
		bit hit;
		logic [31:0] elapsed;
		hit = 1'b0;
		case (c.mode)
			MODE_SEND: begin
				if (c.target_id >= NODE_LIMIT || c.command_code == hb_code) begin
					awaited_events.push_back(mk_event(EV_UNTRACKED, 0, c.target_id,
						c.command_code, c.now_ms, 4'd0, 1'b1));
				end else begin
					for (i = 0; i < SLOTS && !hit; i++) begin
						if (!sl_pend[i]) begin
							hit = 1'b1;
							sl_pend[i] = 1'b1;
							sl_tgt[i] = c.target_id;
							sl_code[i] = c.command_code;
							sl_stamp[i] = c.now_ms;
							sl_sent[i] = c.now_ms;
							sl_retry[i] = '0;
							pend_cnt++;
							awaited_events.push_back(mk_event(EV_ADDED, i, c.target_id,
								c.command_code, c.now_ms, 4'd0, 1'b1));
						end
					end
					if (!hit)
						awaited_events.push_back(mk_event(EV_FULL, 0, c.target_id,
							c.command_code, c.now_ms, 4'd0, 1'b1));
				end
			end
			MODE_ACK: begin
				for (i = 0; i < SLOTS && !hit; i++) begin
					if (sl_pend[i] && sl_tgt[i] == c.target_id && sl_stamp[i] == c.echoed_stamp
							&& sl_code[i] == c.command_code) begin
						hit = 1'b1;
						sl_pend[i] = 1'b0;
						pend_cnt--;
						awaited_events.push_back(mk_event(EV_ACK_MATCH, i, c.target_id,
							c.command_code, c.echoed_stamp, sl_retry[i], 1'b1));
					end
				end
				if (!hit)
					awaited_events.push_back(mk_event(EV_ACK_MISS, 0, c.target_id,
						c.command_code, c.echoed_stamp, 4'd0, 1'b1));
			end
			MODE_TICK: begin
				for (i = 0; i < SLOTS; i++) begin
					elapsed = c.now_ms - sl_sent[i];
					if (sl_pend[i] && elapsed >= {16'd0, timeout_ms}) begin
						if (sl_retry[i] >= retry_max) begin
							sl_pend[i] = 1'b0;
							pend_cnt--;
							awaited_events.push_back(mk_event(EV_GAVE_UP, i, sl_tgt[i],
								sl_code[i], sl_stamp[i], sl_retry[i], 1'b0));
						end else begin
							sl_retry[i] = sl_retry[i] + 4'd1;
							sl_sent[i] = c.now_ms;
							awaited_events.push_back(mk_event(EV_RESEND, i, sl_tgt[i],
								sl_code[i], sl_stamp[i], sl_retry[i], 1'b0));
						end
					end
				end
				awaited_events.push_back(mk_event(EV_SCAN_DONE, 0, 8'd0, 8'd0, 32'd0,
					4'd0, 1'b1));
			end
			default: ;
		endcase
	endtask

	task automatic push_cmd(input cmd_t c);
		int gap;
		gap = draw_gap(tx_burst);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		do @(posedge clk); while (!(in_valid && in_ready));
		track_cmd(c);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			CFG_TIMEOUT: timeout_ms = val;
			CFG_RETRY_LIMIT: retry_max = val[3:0];
			CFG_HEARTBEAT: hb_code = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain, then leave room for a scan still running after a silent word
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_events.size() != 0)
			@(posedge clk);
		repeat (2 * SLOTS + 4) @(posedge clk);
	endtask

	task automatic draw_cmd(output cmd_t c);
		int pick;
		int s;
		logic [31:0] reach;
		reach = {16'd0, timeout_ms};
		c.mode = MODE_SEND;
		c.target_id = 8'($urandom_range(0, NODE_LIMIT - 1));
		c.command_code = 8'($urandom);
		c.echoed_stamp = $urandom;
		c.now_ms = run_ms + $urandom_range(0, 3);
		pick = $urandom_range(0, 99);
		if (pick < 38) begin
			if ($urandom_range(0, 9) == 0)
				c.target_id = 8'($urandom_range(NODE_LIMIT, 255));
			if ($urandom_range(0, 9) == 0)
				c.command_code = hb_code;
			run_ms = c.now_ms;
		end else if (pick < 68) begin
			c.mode = MODE_ACK;
			s = $urandom_range(0, SLOTS - 1);
			if ($urandom_range(0, 9) == 0) begin
				c.target_id = 8'($urandom);
			end else if (sl_pend[s] && $urandom_range(0, 5) != 0) begin
				c.target_id = sl_tgt[s];
				c.command_code = sl_code[s];
				c.echoed_stamp = sl_stamp[s];
				// near miss on one field in some draws, else an exact match
				case ($urandom_range(0, 9))
					0: c.target_id ^= 8'd1 << $urandom_range(0, 3);
					1: c.command_code ^= 8'd1 << $urandom_range(0, 7);
					2: c.echoed_stamp ^= 32'd1 << $urandom_range(0, 31);
					default: ;
				endcase
			end
		end else if (pick < 95) begin
			c.mode = MODE_TICK;
			if ($urandom_range(0, 24) == 0)
				c.now_ms = $urandom;
			else
				c.now_ms = run_ms + $urandom_range(0, 2 * reach + 2);
			run_ms = c.now_ms;
		end else begin
			c.mode = MODE_IDLE;
			c.target_id = 8'($urandom);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			words_seen++;
			if (awaited_events.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected word: %s", fmt_res(out_data));
			end else begin
				want = awaited_events.pop_front();
				if (want.event_res !== out_data.event_res || want.slot !== out_data.slot
						|| want.out_target !== out_data.out_target
						|| want.out_code !== out_data.out_code
						|| want.out_stamp !== out_data.out_stamp
						|| want.attempt !== out_data.attempt
						|| want.pending_count !== out_data.pending_count
						|| want.last !== out_data.last) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch: expected %s, got %s", fmt_res(want),
							fmt_res(out_data));
				end
			end
		end
	end

	// result side: random stalls, and one long hold so the tracker backs up
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && words_seen >= 150) begin
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
			end else begin
				rx_gap = draw_gap(rx_burst);
				if (rx_gap > 0) begin
					out_ready <= 1'b0;
					repeat (rx_gap) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin
		#4_000_000;
		$display("FAIL command_ack_retry_tracker_top");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		clear_table();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < 24; k++) begin
			push_cmd(dir_rows[k].c);
			if (dir_rows[k].chk)
				awaited_events[awaited_events.size() - 1] = dir_rows[k].r;
		end

		for (p = 0; p < 6; p++) begin
			settle();
			case (p)
				0: begin
					set_timeout = 16'd0;
					set_retry = 4'd0;
					set_hb = 8'h00;
				end
				1: begin
					set_timeout = 16'd1;
					set_retry = 4'd15;
					set_hb = 8'hFF;
				end
				2: begin
					set_timeout = 16'hFFFF;
					set_retry = 4'd2;
					set_hb = 8'h80;
				end
				default: begin
					set_timeout = 16'($urandom_range(1, 300));
					set_retry = 4'($urandom_range(0, 15));
					set_hb = 8'($urandom);
				end
			endcase
			pad = 12'($urandom);
			write_reg(CFG_TIMEOUT, set_timeout);
			write_reg(CFG_RETRY_LIMIT, {pad, set_retry});
			write_reg(CFG_HEARTBEAT, {pad[7:0], set_hb});
			if (p == 1)
				write_reg(CFG_SPARE, 16'($urandom));
			run_ms = $urandom;
			n = 0;
			while (n < 65) begin
				draw_cmd(item);
				push_cmd(item);
				if (item.mode != MODE_IDLE)
					n++;
			end
		end

		settle();
		if (fault_count == 0 && awaited_events.size() == 0)
			$display("PASS command_ack_retry_tracker_top");
		else
			$display("FAIL command_ack_retry_tracker_top");
		$finish;
	end

endmodule
